### rtl/core/cir_pkg.sv
// Shared constants and bundle types for the two-body collision impulse resolver.
// Used by the top level and by the pipelined square-root and divider units.
`default_nettype none
package cir_pkg;

    localparam int NORM_BITS = 30;
    localparam logic [16:0] ELAST_ONE = 17'h10000;

    localparam int SQRT_QW = 32;
    localparam int MASS_QW = 32;
    localparam int NORM_QW = 31;

    typedef struct packed {
        logic               sx;
        logic               sy;
        logic               deg;
        logic signed [32:0] dvx;
        logic signed [32:0] dvy;
        logic [3:0][31:0]   vel;
    } t_ctx;

    typedef struct packed {
        logic [31:0] ma;
        logic [31:0] mb;
        logic [32:0] sum;
    } t_mass;

    typedef struct packed {
        t_ctx        ctx;
        logic [30:0] ux;
        logic [30:0] uy;
    } t_sq_pl;

    typedef struct packed {
        t_ctx        ctx;
        logic [29:0] ra;
        logic [29:0] rb;
        logic [17:0] coeff;
    } t_dv_pl;

endpackage
`default_nettype wire

### rtl/core/cir_sqrt.sv
// Pipelined integer square root, one result bit per register stage.
// Carries an opaque side payload alongside; defaults from cir_pkg.
`default_nettype none
module cir_sqrt #(
    parameter int QW = cir_pkg::SQRT_QW,
    parameter int PW = 1
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_en,
    input  wire logic            i_valid,
    input  wire logic [2*QW-1:0] i_rad,
    input  wire logic [PW-1:0]   i_pl,
    output logic                 o_valid,
    output logic [QW-1:0]        o_root,
    output logic [PW-1:0]        o_pl
);
    localparam int RW = 2 * QW;

    logic          r_v    [1:QW];
    logic [RW-1:0] r_rem  [1:QW-1];
    logic [QW-1:0] r_root [1:QW];
    logic [PW-1:0] r_pl   [1:QW];

    for (genvar k = 0; k < QW; k++) begin : g_step
        localparam int B = QW - 1 - k;
        logic          v_in;
        logic [RW-1:0] rem_in;
        logic [QW-1:0] root_in;
        logic [PW-1:0] pl_in;
        logic [RW-1:0] trial;
        logic          take;

        if (k == 0) begin : g_first
            assign v_in    = i_valid;
            assign rem_in  = i_rad;
            assign root_in = '0;
            assign pl_in   = i_pl;
        end else begin : g_next
            assign v_in    = r_v[k];
            assign rem_in  = r_rem[k];
            assign root_in = r_root[k];
            assign pl_in   = r_pl[k];
        end

        assign trial = (RW'(root_in) << (B + 1)) | (RW'(1) << (2 * B));
        assign take  = (rem_in >= trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (i_en) begin
                r_v[k+1] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_root[k+1] <= root_in | (QW'(take) << B);
                r_pl[k+1]   <= pl_in;
            end
        end

        if (k < QW - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k+1] <= take ? (rem_in - trial) : rem_in;
                end
            end
        end
    end

    assign o_valid = r_v[QW];
    assign o_root  = r_root[QW];
    assign o_pl    = r_pl[QW];

endmodule
`default_nettype wire

### rtl/core/cir_div.sv
// Pipelined restoring divider: two numerators over one shared denominator,
// one quotient bit per register stage, with a side payload; defaults from cir_pkg.
`default_nettype none
module cir_div #(
    parameter int NW = 62,
    parameter int DW = 33,
    parameter int QW = cir_pkg::MASS_QW,
    parameter int PW = 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_valid,
    input  wire logic [NW-1:0] i_num_a,
    input  wire logic [NW-1:0] i_num_b,
    input  wire logic [DW-1:0] i_den,
    input  wire logic [PW-1:0] i_pl,
    output logic               o_valid,
    output logic [QW-1:0]      o_quo_a,
    output logic [QW-1:0]      o_quo_b,
    output logic [PW-1:0]      o_pl
);
    localparam int CW = (NW > DW + QW) ? NW : DW + QW;

    logic          r_v     [1:QW];
    logic [NW-1:0] r_rem_a [1:QW-1];
    logic [NW-1:0] r_rem_b [1:QW-1];
    logic [DW-1:0] r_den   [1:QW-1];
    logic [QW-1:0] r_quo_a [1:QW];
    logic [QW-1:0] r_quo_b [1:QW];
    logic [PW-1:0] r_pl    [1:QW];

    for (genvar k = 0; k < QW; k++) begin : g_step
        localparam int B = QW - 1 - k;
        logic          v_in;
        logic [NW-1:0] rem_a_in;
        logic [NW-1:0] rem_b_in;
        logic [DW-1:0] den_in;
        logic [QW-1:0] quo_a_in;
        logic [QW-1:0] quo_b_in;
        logic [PW-1:0] pl_in;
        logic [CW-1:0] sub;
        logic [CW-1:0] diff_a;
        logic [CW-1:0] diff_b;
        logic          take_a;
        logic          take_b;

        if (k == 0) begin : g_first
            assign v_in     = i_valid;
            assign rem_a_in = i_num_a;
            assign rem_b_in = i_num_b;
            assign den_in   = i_den;
            assign quo_a_in = '0;
            assign quo_b_in = '0;
            assign pl_in    = i_pl;
        end else begin : g_next
            assign v_in     = r_v[k];
            assign rem_a_in = r_rem_a[k];
            assign rem_b_in = r_rem_b[k];
            assign den_in   = r_den[k];
            assign quo_a_in = r_quo_a[k];
            assign quo_b_in = r_quo_b[k];
            assign pl_in    = r_pl[k];
        end

        assign sub    = CW'(den_in) << B;
        assign take_a = (CW'(rem_a_in) >= sub);
        assign take_b = (CW'(rem_b_in) >= sub);
        assign diff_a = CW'(rem_a_in) - sub;
        assign diff_b = CW'(rem_b_in) - sub;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (i_en) begin
                r_v[k+1] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_quo_a[k+1] <= quo_a_in | (QW'(take_a) << B);
                r_quo_b[k+1] <= quo_b_in | (QW'(take_b) << B);
                r_pl[k+1]    <= pl_in;
            end
        end

        if (k < QW - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem_a[k+1] <= take_a ? diff_a[NW-1:0] : rem_a_in;
                    r_rem_b[k+1] <= take_b ? diff_b[NW-1:0] : rem_b_in;
                    r_den[k+1]   <= den_in;
                end
            end
        end
    end

    assign o_valid = r_v[QW];
    assign o_quo_a = r_quo_a[QW];
    assign o_quo_b = r_quo_b[QW];
    assign o_pl    = r_pl[QW];

endmodule
`default_nettype wire

### rtl/core/collision_impulse_resolver_top.sv
// Requests pass stages 1 to 6, the square root, the normal divider and stages 7 to 13.
// Throughput: one request per cycle; a held output stalls the whole pipeline in place.
// The rate is set by the 32-stage square root and 31-stage normal divider, fully pipelined.
// Reset is synchronous and active low; it clears only the stage valid bits.
// Depends on cir_pkg, cir_sqrt and cir_div.
`default_nettype none
module collision_impulse_resolver_top (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    // mass_a, mass_b, centre_a_x, centre_a_y, centre_b_x, centre_b_y,
    // vel_a_x, vel_a_y, vel_b_x, vel_b_y, inv_elast_a, inv_elast_b, zero pad
    input  wire logic [359:0] i_s_axis_tdata,
    output logic              o_m_axis_tvalid,
    input  wire logic         i_m_axis_tready,
    // new_vel_a_x, new_vel_a_y, new_vel_b_x, new_vel_b_y
    output logic [127:0]      o_m_axis_tdata,
    // degenerate, saturated
    output logic [1:0]        o_m_axis_tuser
);
    localparam int SQ_PW = $bits(cir_pkg::t_sq_pl);
    localparam int DV_PW = $bits(cir_pkg::t_dv_pl);

    logic en;

    // Input unpacking
    logic [31:0] w_ma, w_mb, w_cax, w_cay, w_cbx, w_cby;
    logic [16:0] w_ia, w_ib, w_ea, w_eb;

    // Stage 1 to 6
    logic               r1_v, r2_v, r3_v, r4_v, r5_v, r6_v;
    logic [31:0]        r1_ma, r1_mb;
    logic [32:0]        r1_dx, r1_dy;
    logic [3:0][31:0]   r1_vel;
    logic [16:0]        r1_ea, r1_eb;
    logic               r1_mdeg;
    logic [32:0]        w_ndx, w_ndy;
    logic [33:0]        w_eprod;
    cir_pkg::t_ctx      r2_ctx, r3_ctx, r4_ctx, r5_ctx, r6_ctx;
    cir_pkg::t_mass     r2_mass, r3_mass, r4_mass, r5_mass, r6_mass;
    logic [31:0]        r2_ux, r2_uy;
    logic [32:0]        r2_eprod;
    logic [17:0]        r3_coeff, r4_coeff, r5_coeff, r6_coeff;
    logic [30:0]        r3_ux, r3_uy, r4_ux, r4_uy, r5_ux, r5_uy, r6_ux, r6_uy;
    logic [31:0]        w_m2;
    logic [30:0]        w_ax, w_ay, w_am, w_bx, w_by, w_bm;
    logic [61:0]        w_sqx, w_sqy, r5_sqx, r5_sqy;
    logic [62:0]        r6_q;

    // Square root and dividers
    cir_pkg::t_sq_pl    w_sq_in, w_sq_pl;
    logic               w_sq_v, w_md_v, w_nd_v;
    logic [31:0]        w_len, w_ra, w_rb;
    logic [17:0]        w_md_coeff;
    cir_pkg::t_dv_pl    w_dv_in, w_dv_pl;
    logic [30:0]        w_nxm, w_nym;

    // Stage 7 to 13
    logic               r7_v, r8_v, r9_v, r10_v, r11_v, r12_v, r13_v;
    cir_pkg::t_ctx      r7_ctx, r8_ctx, r9_ctx, r10_ctx, r11_ctx, r12_ctx, r13_ctx;
    logic signed [31:0] r7_nx, r7_ny, w_nx, w_ny;
    logic [30:0]        r7_nxm, r7_nym, r8_nxm, r8_nym, r9_nxm, r9_nym;
    logic [30:0]        r10_nxm, r10_nym, r11_nxm, r11_nym;
    logic [28:0]        r7_ka, r7_kb, r8_ka, r8_kb, r9_ka, r9_kb, r10_ka, r10_kb;
    logic [47:0]        w_pka, w_pkb;
    logic signed [64:0] w_pdx, w_pdy;
    logic signed [63:0] r8_pdx, r8_pdy, r9_s;
    logic [63:0]        w_sabs;
    logic               r10_dvs, r11_dvs;
    logic [32:0]        r10_dvm;
    logic [61:0]        w_ja, w_jb;
    logic [33:0]        r11_jam, r11_jbm;
    logic [64:0]        w_p0, w_p1, w_p2, w_p3;
    logic [3:0][34:0]   r12_pm;
    logic [3:0]         r12_psg;
    logic [3:0][36:0]   w_res, r13_res;
    logic [36:0]        w_term;
    logic               w_neg;

    // Output
    logic [3:0]         w_hi, w_lo;
    logic [3:0][31:0]   w_out_vel;
    logic               r_out_v;
    logic [3:0][31:0]   r_out_vel;
    logic               r_out_deg, r_out_sat;

    assign en              = !r_out_v || i_m_axis_tready;
    assign o_s_axis_tready = en;

    assign w_ma  = i_s_axis_tdata[31:0];
    assign w_mb  = i_s_axis_tdata[63:32];
    assign w_cax = i_s_axis_tdata[95:64];
    assign w_cay = i_s_axis_tdata[127:96];
    assign w_cbx = i_s_axis_tdata[159:128];
    assign w_cby = i_s_axis_tdata[191:160];
    assign w_ia  = i_s_axis_tdata[336:320];
    assign w_ib  = i_s_axis_tdata[353:337];
    assign w_ea  = cir_pkg::ELAST_ONE - ((w_ia > cir_pkg::ELAST_ONE) ? cir_pkg::ELAST_ONE : w_ia);
    assign w_eb  = cir_pkg::ELAST_ONE - ((w_ib > cir_pkg::ELAST_ONE) ? cir_pkg::ELAST_ONE : w_ib);

    assign w_ndx   = 33'd0 - r1_dx;
    assign w_ndy   = 33'd0 - r1_dy;
    assign w_eprod = {17'd0, r1_ea} * {17'd0, r1_eb};

    assign w_m2 = (r2_ux > r2_uy) ? r2_ux : r2_uy;

    always_comb begin
        if (w_m2[31]) begin
            w_ax = r2_ux[31:1];
            w_ay = r2_uy[31:1];
            w_am = w_m2[31:1];
        end else begin
            w_ax = r2_ux[30:0];
            w_ay = r2_uy[30:0];
            w_am = w_m2[30:0];
        end
        if (w_am[30:15] == '0) begin
            w_ax = w_ax << 16;
            w_ay = w_ay << 16;
            w_am = w_am << 16;
        end
        if (w_am[30:23] == '0) begin
            w_ax = w_ax << 8;
            w_ay = w_ay << 8;
            w_am = w_am << 8;
        end
    end

    always_comb begin
        w_bx = r3_ux;
        w_by = r3_uy;
        w_bm = (r3_ux > r3_uy) ? r3_ux : r3_uy;
        if (w_bm[30:27] == '0) begin
            w_bx = w_bx << 4;
            w_by = w_by << 4;
            w_bm = w_bm << 4;
        end
        if (w_bm[30:29] == '0) begin
            w_bx = w_bx << 2;
            w_by = w_by << 2;
            w_bm = w_bm << 2;
        end
        if (!w_bm[30]) begin
            w_bx = w_bx << 1;
            w_by = w_by << 1;
        end
    end

    assign w_sqx = r4_ux * r4_ux;
    assign w_sqy = r4_uy * r4_uy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
            r6_v <= 1'b0;
        end else if (en) begin
            r1_v <= i_s_axis_tvalid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r5_v <= r4_v;
            r6_v <= r5_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_ma   <= w_ma;
            r1_mb   <= w_mb;
            r1_dx   <= {w_cbx[31], w_cbx} - {w_cax[31], w_cax};
            r1_dy   <= {w_cby[31], w_cby} - {w_cay[31], w_cay};
            r1_vel  <= i_s_axis_tdata[319:192];
            r1_ea   <= w_ea;
            r1_eb   <= w_eb;
            r1_mdeg <= (w_ma == '0) || (w_mb == '0);

            r2_ux        <= r1_dx[32] ? w_ndx[31:0] : r1_dx[31:0];
            r2_uy        <= r1_dy[32] ? w_ndy[31:0] : r1_dy[31:0];
            r2_ctx.sx    <= r1_dx[32];
            r2_ctx.sy    <= r1_dy[32];
            r2_ctx.deg   <= r1_mdeg || ((r1_dx == '0) && (r1_dy == '0));
            r2_ctx.dvx   <= {r1_vel[2][31], r1_vel[2]} - {r1_vel[0][31], r1_vel[0]};
            r2_ctx.dvy   <= {r1_vel[3][31], r1_vel[3]} - {r1_vel[1][31], r1_vel[1]};
            r2_ctx.vel   <= r1_vel;
            r2_mass.ma   <= r1_ma;
            r2_mass.mb   <= r1_mb;
            r2_mass.sum  <= {1'b0, r1_ma} + {1'b0, r1_mb};
            r2_eprod     <= w_eprod[32:0];

            r3_ctx   <= r2_ctx;
            r3_mass  <= r2_mass;
            r3_ux    <= w_ax;
            r3_uy    <= w_ay;
            r3_coeff <= 18'(cir_pkg::ELAST_ONE) + {1'b0, r2_eprod[32:16]};

            r4_ctx   <= r3_ctx;
            r4_mass  <= r3_mass;
            r4_ux    <= w_bx;
            r4_uy    <= w_by;
            r4_coeff <= r3_coeff;

            r5_ctx   <= r4_ctx;
            r5_mass  <= r4_mass;
            r5_ux    <= r4_ux;
            r5_uy    <= r4_uy;
            r5_sqx   <= w_sqx;
            r5_sqy   <= w_sqy;
            r5_coeff <= r4_coeff;

            r6_ctx   <= r5_ctx;
            r6_mass  <= r5_mass;
            r6_ux    <= r5_ux;
            r6_uy    <= r5_uy;
            r6_q     <= {1'b0, r5_sqx} + {1'b0, r5_sqy};
            r6_coeff <= r5_coeff;
        end
    end

    assign w_sq_in.ctx = r6_ctx;
    assign w_sq_in.ux  = r6_ux;
    assign w_sq_in.uy  = r6_uy;

    cir_sqrt #(
        .QW (cir_pkg::SQRT_QW),
        .PW (SQ_PW)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r6_v),
        .i_rad   ({1'b0, r6_q}),
        .i_pl    (w_sq_in),
        .o_valid (w_sq_v),
        .o_root  (w_len),
        .o_pl    (w_sq_pl)
    );

    cir_div #(
        .NW (32 + cir_pkg::NORM_BITS),
        .DW (33),
        .QW (cir_pkg::MASS_QW),
        .PW (18)
    ) u_mass_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r6_v),
        .i_num_a ({r6_mass.mb, {cir_pkg::NORM_BITS{1'b0}}}),
        .i_num_b ({r6_mass.ma, {cir_pkg::NORM_BITS{1'b0}}}),
        .i_den   (r6_mass.sum),
        .i_pl    (r6_coeff),
        .o_valid (w_md_v),
        .o_quo_a (w_ra),
        .o_quo_b (w_rb),
        .o_pl    (w_md_coeff)
    );

    assign w_dv_in.ctx   = w_sq_pl.ctx;
    assign w_dv_in.ra    = w_ra[29:0];
    assign w_dv_in.rb    = w_rb[29:0];
    assign w_dv_in.coeff = w_md_coeff;

    cir_div #(
        .NW (31 + cir_pkg::NORM_BITS),
        .DW (cir_pkg::SQRT_QW),
        .QW (cir_pkg::NORM_QW),
        .PW (DV_PW)
    ) u_norm_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (w_sq_v && w_md_v),
        .i_num_a ({w_sq_pl.ux, {cir_pkg::NORM_BITS{1'b0}}}),
        .i_num_b ({w_sq_pl.uy, {cir_pkg::NORM_BITS{1'b0}}}),
        .i_den   (w_len),
        .i_pl    (w_dv_in),
        .o_valid (w_nd_v),
        .o_quo_a (w_nxm),
        .o_quo_b (w_nym),
        .o_pl    (w_dv_pl)
    );

    assign w_nx  = w_dv_pl.ctx.sx ? -$signed({1'b0, w_nxm}) : $signed({1'b0, w_nxm});
    assign w_ny  = w_dv_pl.ctx.sy ? -$signed({1'b0, w_nym}) : $signed({1'b0, w_nym});
    assign w_pka = w_dv_pl.coeff * w_dv_pl.ra;
    assign w_pkb = w_dv_pl.coeff * w_dv_pl.rb;

    assign w_pdx = $signed(r7_ctx.dvx) * r7_nx;
    assign w_pdy = $signed(r7_ctx.dvy) * r7_ny;

    assign w_sabs = r9_s[63] ? (64'd0 - r9_s) : r9_s;

    assign w_ja = r10_dvm * r10_ka;
    assign w_jb = r10_dvm * r10_kb;

    assign w_p0 = r11_jam * r11_nxm;
    assign w_p1 = r11_jam * r11_nym;
    assign w_p2 = r11_jbm * r11_nxm;
    assign w_p3 = r11_jbm * r11_nym;

    always_comb begin
        w_res  = '0;
        w_term = '0;
        w_neg  = 1'b0;
        for (int k = 0; k < 4; k++) begin
            w_neg    = r12_psg[k] ^ (k >= 2);
            w_term   = {2'b00, r12_pm[k]};
            w_res[k] = {{5{r12_ctx.vel[k][31]}}, r12_ctx.vel[k]}
                       + (w_neg ? (37'd0 - w_term) : w_term);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_v  <= 1'b0;
            r8_v  <= 1'b0;
            r9_v  <= 1'b0;
            r10_v <= 1'b0;
            r11_v <= 1'b0;
            r12_v <= 1'b0;
            r13_v <= 1'b0;
        end else if (en) begin
            r7_v  <= w_nd_v;
            r8_v  <= r7_v;
            r9_v  <= r8_v;
            r10_v <= r9_v;
            r11_v <= r10_v;
            r12_v <= r11_v;
            r13_v <= r12_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r7_ctx <= w_dv_pl.ctx;
            r7_nx  <= w_nx;
            r7_ny  <= w_ny;
            r7_nxm <= w_nxm;
            r7_nym <= w_nym;
            r7_ka  <= w_pka[46:18];
            r7_kb  <= w_pkb[46:18];

            r8_ctx <= r7_ctx;
            r8_pdx <= w_pdx[63:0];
            r8_pdy <= w_pdy[63:0];
            r8_nxm <= r7_nxm;
            r8_nym <= r7_nym;
            r8_ka  <= r7_ka;
            r8_kb  <= r7_kb;

            r9_ctx <= r8_ctx;
            r9_s   <= r8_pdx + r8_pdy;
            r9_nxm <= r8_nxm;
            r9_nym <= r8_nym;
            r9_ka  <= r8_ka;
            r9_kb  <= r8_kb;

            r10_ctx <= r9_ctx;
            r10_dvs <= r9_s[63];
            r10_dvm <= w_sabs[62:30];
            r10_nxm <= r9_nxm;
            r10_nym <= r9_nym;
            r10_ka  <= r9_ka;
            r10_kb  <= r9_kb;

            r11_ctx <= r10_ctx;
            r11_dvs <= r10_dvs;
            r11_jam <= w_ja[61:28];
            r11_jbm <= w_jb[61:28];
            r11_nxm <= r10_nxm;
            r11_nym <= r10_nym;

            r12_ctx    <= r11_ctx;
            r12_pm[0]  <= w_p0[64:30];
            r12_pm[1]  <= w_p1[64:30];
            r12_pm[2]  <= w_p2[64:30];
            r12_pm[3]  <= w_p3[64:30];
            r12_psg[0] <= r11_dvs ^ r11_ctx.sx;
            r12_psg[1] <= r11_dvs ^ r11_ctx.sy;
            r12_psg[2] <= r11_dvs ^ r11_ctx.sx;
            r12_psg[3] <= r11_dvs ^ r11_ctx.sy;

            r13_ctx <= r12_ctx;
            r13_res <= w_res;
        end
    end

    always_comb begin
        w_hi      = '0;
        w_lo      = '0;
        w_out_vel = '0;
        for (int k = 0; k < 4; k++) begin
            w_hi[k] = !r13_res[k][36] && (r13_res[k][35:31] != '0);
            w_lo[k] = r13_res[k][36] && (r13_res[k][35:31] != '1);
            if (r13_ctx.deg) begin
                w_out_vel[k] = r13_ctx.vel[k];
            end else if (w_hi[k]) begin
                w_out_vel[k] = 32'h7FFF_FFFF;
            end else if (w_lo[k]) begin
                w_out_vel[k] = 32'h8000_0000;
            end else begin
                w_out_vel[k] = r13_res[k][31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en) begin
            r_out_v <= r13_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_vel <= w_out_vel;
            r_out_deg <= r13_ctx.deg;
            r_out_sat <= !r13_ctx.deg && ((w_hi | w_lo) != '0);
        end
    end

    assign o_m_axis_tvalid = r_out_v;
    assign o_m_axis_tdata  = r_out_vel;
    assign o_m_axis_tuser  = {r_out_sat, r_out_deg};

endmodule
`default_nettype wire
